[sv/gsed_pkg.sv]
`default_nettype none

package gsed_pkg;

	localparam int PIX_W = 8;
	localparam int IMG_WIDTH_W = 12;
	localparam int IMG_HEIGHT_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int ROW_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RST = 12'd640;
	localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
	localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;
	localparam int MIN_DIM = 3;

	// gray weights, sum is 256
	localparam logic [7:0] COEF_B = 8'd29;
	localparam logic [7:0] COEF_G = 8'd150;
	localparam logic [7:0] COEF_R = 8'd77;
	localparam int GRAY_SHIFT = 8;
	localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

	typedef logic [PIX_W-1:0] pix_t;

	function automatic pix_t rgb_to_gray(input pix_t b, input pix_t g, input pix_t r);
		logic [15:0] acc;
		acc = 16'(b) * 16'(COEF_B) + 16'(g) * 16'(COEF_G) + 16'(r) * 16'(COEF_R);
		return pix_t'(acc >> GRAY_SHIFT);
	endfunction

endpackage

`default_nettype wire

[sv/gray_sobel_edge_stream_unit.sv]
// Sobel 3x3 edge magnitude on a raster BGR pixel stream.
// Pipeline: 2 register stages, stage 1 and the output register.
// Throughput: one pixel per cycle unless stalled; set by the line buffer read at accept.
// Reset (arst_n low, async): counters, window cells, valid flags cleared, width 640, height 480.
// Line buffers are not cleared; entries may be read before they are written.
`default_nettype none

module gray_sobel_edge_stream_unit import gsed_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PIX_W-1:0]      blue,
	input  wire logic [PIX_W-1:0]      green,
	input  wire logic [PIX_W-1:0]      red,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [PIX_W-1:0]           edge_magnitude,
	output logic                       row_end,
	output logic                       frame_end
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW = 15;
	localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
	localparam logic [CMPW-1:0] MIN_C = CMPW'(MIN_DIM);

	logic [IMG_WIDTH_W-1:0]  image_width_q;
	logic [IMG_HEIGHT_W-1:0] image_height_q;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	pix_t line_older [MAX_WIDTH];
	pix_t line_newer [MAX_WIDTH];
	pix_t top_s1, mid_s1;

	pix_t win_q [6];

	logic          v_s1;
	logic          prod_s1;
	logic          last_col_s1;
	logic          last_row_s1;
	logic [CW-1:0] col_s1;
	pix_t          gray_s1;

	logic [PIX_W-1:0] mag_q;
	logic             row_end_q, frame_end_q, out_valid_q;

	// effective dimensions
	logic [CMPW-1:0] w_raw, h_raw, w_eff, h_eff;
	logic            last_col, last_row, produce;
	logic            in_xfer, s1_adv, out_free;

	always_comb begin
		w_raw = CMPW'(image_width_q);
		h_raw = CMPW'(image_height_q);
		if (w_raw < MIN_C) w_eff = MIN_C;
		else if (w_raw > MAX_W_C) w_eff = MAX_W_C;
		else w_eff = w_raw;
		if (h_raw < MIN_C) h_eff = MIN_C;
		else if (h_raw > CMPW'(HEIGHT_LIMIT)) h_eff = CMPW'(HEIGHT_LIMIT);
		else h_eff = h_raw;
		last_col = (CMPW'(col_q) + CMPW'(1)) >= w_eff;
		last_row = (CMPW'(row_q) + CMPW'(1)) >= h_eff;
		produce  = (row_q >= ROW_W'(2)) && (CMPW'(col_q) >= CMPW'(2));
	end

	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = v_s1 && (!prod_s1 || out_free);
	assign in_stall = v_s1 && !s1_adv;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q <= cfg_data[IMG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (in_xfer) v_s1 <= 1'b1;
			else if (s1_adv) v_s1 <= 1'b0;
		end
	end

	// stage 1 payload; line buffer reads happen on the input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			prod_s1     <= produce;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			col_s1      <= col_q;
			gray_s1     <= rgb_to_gray(blue, green, red);
			top_s1      <= line_older[col_q];
			mid_s1      <= line_newer[col_q];
		end
	end

	// write back when the pixel leaves stage 1; the next read is always a different column
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			line_older[col_s1] <= mid_s1;
			line_newer[col_s1] <= gray_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= gray_s1;
		end
	end

	// Sobel: p1 p4 p7 left column, p2 p8 middle column, p3 p6 p9 new column
	logic signed [11:0] gx, gy;
	logic        [10:0] ax, ay;
	logic        [11:0] mag_sum;
	pix_t               mag;

	always_comb begin
		gx = (12'(top_s1) + {3'b0, mid_s1, 1'b0} + 12'(gray_s1))
			- (12'(win_q[0]) + {3'b0, win_q[1], 1'b0} + 12'(win_q[2]));
		gy = (12'(win_q[0]) + {3'b0, win_q[3], 1'b0} + 12'(top_s1))
			- (12'(win_q[2]) + {3'b0, win_q[5], 1'b0} + 12'(gray_s1));
		ax = gx[11] ? 11'(-gx) : gx[10:0];
		ay = gy[11] ? 11'(-gy) : gy[10:0];
		mag_sum = 12'(ax) + 12'(ay);
		mag = (mag_sum > 12'(MAG_MAX)) ? MAG_MAX : mag_sum[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && prod_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && prod_s1) begin
			mag_q       <= mag;
			row_end_q   <= last_col_s1;
			frame_end_q <= last_col_s1 && last_row_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign edge_magnitude = mag_q;
	assign row_end        = row_end_q;
	assign frame_end      = frame_end_q;

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench import gsed_pkg::*;;

	localparam int LINE_MAX = 2048;
	localparam int ROWS_MAX = 4096;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PIXELS = 460;
	localparam int RESET_GEOM_PIXELS = 40;
	localparam int PRESSURE_PIXELS = 24;
	localparam int LONG_HOLD = 80;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		pix_t mag;
		logic row_last;
		logic frame_last;
	} edge_t;

	typedef struct {
		bit                    set_geom;
		logic [CFG_DATA_W-1:0] w_data;
		logic [CFG_DATA_W-1:0] h_data;
		pix_t                  b;
		pix_t                  g;
		pix_t                  r;
		bit                    known;
		edge_t                 want;
	} pixel_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	pix_t                  blue = '0;
	pix_t                  green = '0;
	pix_t                  red = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	pix_t                  edge_magnitude;
	logic                  row_end;
	logic                  frame_end;

	// shared stimulus knobs, written by the sender only
	bit steady = 1'b0;
	int hold_off_requests = 0;

	int mismatch_count = 0;
	int cycle_count = 0;
	edge_t pending_edges[$];

	// predictor state
	pix_t gray_row_older [LINE_MAX];
	pix_t gray_row_newer [LINE_MAX];
	int   window_px [6];
	int   col_pos;
	int   row_pos;
	int   cfg_width;
	int   cfg_height;

	// directed frames: 3x3 geometry; the first pixel closes the row left open before
	// and the next six close that frame
	pixel_row_t directed_rows [34] = '{
		'{1'b1, 13'd2, 13'd0, 8'd90, 8'd200, 8'd10, 1'b0, '0},
		'{1'b0, '0, '0, 8'd12, 8'd40, 8'd200, 1'b0, '0},
		'{1'b0, '0, '0, 8'd250, 8'd3, 8'd77, 1'b0, '0},
		'{1'b0, '0, '0, 8'd128, 8'd128, 8'd128, 1'b0, '0},
		'{1'b0, '0, '0, 8'd0, 8'd180, 8'd60, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd0, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd33, 8'd66, 8'd99, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd0, 1'b1, 1'b1}},
		'{1'b0, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
		'{1'b0, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
		'{1'b0, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 1'b1, 1'b1}},
		'{1'b0, '0, '0, 8'd255, 8'd0, 8'd0, 1'b0, '0},
		'{1'b0, '0, '0, 8'd0, 8'd255, 8'd0, 1'b0, '0},
		'{1'b0, '0, '0, 8'd0, 8'd0, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd255, 8'd0, 1'b0, '0},
		'{1'b0, '0, '0, 8'd0, 8'd255, 8'd255, 1'b0, '0},
		'{1'b0, '0, '0, 8'd255, 8'd0, 8'd255, 1'b0, '0}
	};

	gray_sobel_edge_stream_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.edge_magnitude (edge_magnitude),
		.row_end        (row_end),
		.frame_end      (frame_end)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic int eff_width();
		if (cfg_width < MIN_DIM)
			return MIN_DIM;
		if (cfg_width > LINE_MAX)
			return LINE_MAX;
		return cfg_width;
	endfunction

	function automatic int eff_height();
		if (cfg_height < MIN_DIM)
			return MIN_DIM;
		if (cfg_height > ROWS_MAX)
			return ROWS_MAX;
		return cfg_height;
	endfunction

	// One pixel through the gray conversion, line buffers and 3x3 window.
	function automatic bit advance_pixel(input pix_t b, input pix_t g, input pix_t r,
			output edge_t res);
		int  gray;
		int  top;
		int  mid;
		int  gx;
		int  gy;
		int  mag;
		int  c;
		bit  last_col;
		bit  last_row;
		bit  produced;
		c = col_pos;
		gray = (29 * int'(b) + 150 * int'(g) + 77 * int'(r)) >> 8;
		top = gray_row_older[c];
		mid = gray_row_newer[c];
		last_col = (col_pos + 1 >= eff_width());
		last_row = (row_pos + 1 >= eff_height());
		produced = (row_pos >= 2 && col_pos >= 2);
		res = '0;
		if (produced) begin
			gx = (top + 2 * mid + gray) - (window_px[0] + 2 * window_px[1] + window_px[2]);
			gy = (window_px[0] + 2 * window_px[3] + top) - (window_px[2] + 2 * window_px[5] + gray);
			mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			if (mag > 255)
				mag = 255;
			res.mag = pix_t'(mag);
			res.row_last = last_col;
			res.frame_last = last_col && last_row;
		end
		window_px[0] = window_px[3];
		window_px[1] = window_px[4];
		window_px[2] = window_px[5];
		window_px[3] = top;
		window_px[4] = mid;
		window_px[5] = gray;
		gray_row_older[c] = pix_t'(mid);
		gray_row_newer[c] = pix_t'(gray);
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return produced;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH @%0d: %s", cycle_count, msg);
	endtask

	task automatic check_edge();
		edge_t want;
		if (pending_edges.size() == 0) begin
			report_mismatch($sformatf("unexpected result, magnitude %0d", edge_magnitude));
			return;
		end
		want = pending_edges.pop_front();
		if (edge_magnitude !== want.mag)
			report_mismatch($sformatf("edge_magnitude %0d, want %0d", edge_magnitude, want.mag));
		if (row_end !== want.row_last)
			report_mismatch($sformatf("row_end %b, want %b", row_end, want.row_last));
		if (frame_end !== want.frame_last)
			report_mismatch($sformatf("frame_end %b, want %b", frame_end, want.frame_last));
	endtask

	// Offers one pixel, waits for its transfer, then maybe idles before the next one.
	task automatic send_pixel(input pix_t b, input pix_t g, input pix_t r,
			input bit known, input edge_t want);
		edge_t predicted;
		int    gap;
		in_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		do
			@(posedge clk);
		while (in_stall);
		if (advance_pixel(b, g, r, predicted))
			pending_edges.push_back(known ? want : predicted);
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input bit flat);
		pix_t b;
		pix_t g;
		pix_t r;
		b = flat ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : pix_t'($urandom_range(0, 255));
		g = flat ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : pix_t'($urandom_range(0, 255));
		r = flat ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : pix_t'($urandom_range(0, 255));
		send_pixel(b, g, r, 1'b0, '0);
	endtask

	// Geometry changes only once all results are out and the pipe has drained.
	task automatic program_geometry(input logic [CFG_DATA_W-1:0] w_data,
			input logic [CFG_DATA_W-1:0] h_data);
		in_valid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= w_data;
		@(posedge clk);
		cfg_width = int'(w_data[IMG_WIDTH_W-1:0]);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= h_data;
		@(posedge clk);
		cfg_height = int'(h_data[IMG_HEIGHT_W-1:0]);
		cfg_wr_en <= 1'b0;
	endtask

	// output side: random stalls per transfer, plus long hold-offs on request
	initial begin : drain
		int stall_left;
		int hold_left;
		int holds_served;
		stall_left = 0;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				check_edge();
				stall_left = steady ? 0 : $urandom_range(0, 3);
			end
			if (holds_served != hold_off_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int                    random_pixels;
		int                    w_pick;
		int                    h_pick;
		int                    n;
		bit                    flat;
		logic [CFG_DATA_W-1:0] w_data;
		logic [CFG_DATA_W-1:0] h_data;
		foreach (gray_row_older[i]) begin
			gray_row_older[i] = '0;
			gray_row_newer[i] = '0;
		end
		foreach (window_px[i])
			window_px[i] = 0;
		col_pos = 0;
		row_pos = 0;
		cfg_width = 640;
		cfg_height = 480;
		random_pixels = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: part of the first row of 640 gives no results
		repeat (RESET_GEOM_PIXELS)
			send_random(1'b0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_geom)
				program_geometry(directed_rows[i].w_data, directed_rows[i].h_data);
			send_pixel(directed_rows[i].b, directed_rows[i].g, directed_rows[i].r,
				directed_rows[i].known, directed_rows[i].want);
		end

		// receiver held off while a 4x6 frame is offered back to back
		program_geometry(13'd4, 13'd6);
		steady = 1'b1;
		hold_off_requests++;
		repeat (PRESSURE_PIXELS)
			send_random(1'b0);
		steady = 1'b0;

		while (random_pixels < RANDOM_PIXELS) begin
			steady = ($urandom_range(0, 4) == 0);
			flat = ($urandom_range(0, 3) == 0);
			if (hold_off_requests < 2 && random_pixels >= 150 + 250 * hold_off_requests)
				hold_off_requests++;
			case ($urandom_range(0, 9))
				0: w_pick = $urandom_range(0, 2);
				1: w_pick = $urandom_range(20, 32);
				default: w_pick = $urandom_range(3, 10);
			endcase
			// past row 0 a wider row would read line buffer entries never written
			if (row_pos != 0 && (w_pick < MIN_DIM ? MIN_DIM : w_pick) > eff_width())
				w_pick = eff_width();
			case ($urandom_range(0, 9))
				0: h_pick = $urandom_range(0, 2);
				1: h_pick = $urandom_range(4096, 8191);
				default: h_pick = $urandom_range(3, 6);
			endcase
			w_data = {1'($urandom_range(0, 1)), 12'(w_pick)};
			h_data = 13'(h_pick);
			program_geometry(w_data, h_data);
			n = $urandom_range(eff_width(),
				3 * eff_width() * (eff_height() > 6 ? 6 : eff_height()));
			if (n > 200)
				n = 200;
			if (n > RANDOM_PIXELS - random_pixels)
				n = RANDOM_PIXELS - random_pixels;
			repeat (n) begin
				send_random(flat);
				random_pixels++;
			end
		end

		in_valid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_edges.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

[gray_sobel_edge_stream_unit.f]
sv/gsed_pkg.sv
sv/gray_sobel_edge_stream_unit.sv
dv/testbench.sv
